### sv/circular_dlist_manager_core_defines.svh
// Assertion macros for the list manager core.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef CIRCULAR_DLIST_MANAGER_CORE_DEFINES_SVH
`define CIRCULAR_DLIST_MANAGER_CORE_DEFINES_SVH

// same-cycle implication
`define CDL_ASSERT_NOW(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("cdl assertion failed");

// next-cycle implication
`define CDL_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("cdl assertion failed");

`endif

### sv/cdl_pkg.sv
// Shared types and constants for the list manager core.
// Used by cdl_seq and circular_dlist_manager_core.
package cdl_pkg;

    localparam int NODE_COUNT = 256;
    localparam int LIST_COUNT = 8;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LIST_W     = $clog2(LIST_COUNT);
    localparam int PC_W       = 4;

    typedef enum logic [1:0] {
        OP_INS = 2'd0,
        OP_APP = 2'd1,
        OP_REM = 2'd2,
        OP_POP = 2'd3
    } op_t;

    // link memory read
    typedef enum logic [1:0] {
        RD_NONE,
        RD_HEAD,   // prev at current head
        RD_NODE    // next and prev at the node
    } rd_t;

    // link memory write pair
    typedef enum logic [2:0] {
        WR_NONE,
        WR_SELF,   // next[n]=n, prev[n]=n
        WR_NODE,   // next[n]=h, prev[n]=pv
        WR_NBR,    // next[pv]=n, prev[h]=n
        WR_UNLINK  // next[pv]=nx, prev[nx]=pv
    } wr_t;

    // head and occupied flag update
    typedef enum logic [1:0] {
        HD_KEEP,
        HD_SET,
        HD_UNLINK,
        HD_CLEAR
    } hd_t;

    // jump condition
    typedef enum logic [2:0] {
        C_NEXT,
        C_NULL,
        C_EMPTY,
        C_SKIP,
        C_NO_VICTIM,
        C_SELF
    } cnd_t;

    typedef struct packed {
        rd_t             rd;
        wr_t             wr;
        hd_t             hd;
        cnd_t            cnd;
        logic [PC_W-1:0] target;
        logic            done;
        logic            rem;
        logic            ign;
    } ctrl_t;

    typedef struct packed {
        logic is_null;
        logic empty;
        logic self_loop;
        logic no_victim;
    } stat_t;

endpackage

### sv/cdl_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cdl_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/cdl_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on cdl_pkg.
module cdl_seq import cdl_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  op_t   op,
    input  stat_t stat,
    input  logic  out_free,
    output ctrl_t ctrl,
    output logic  fire,
    output logic  busy
);

    localparam logic [PC_W-1:0] PC_INS   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_INS_E = PC_W'(4);
    localparam logic [PC_W-1:0] PC_APP   = PC_W'(5);
    localparam logic [PC_W-1:0] PC_REM   = PC_W'(8);
    localparam logic [PC_W-1:0] PC_REM_S = PC_W'(11);
    localparam logic [PC_W-1:0] PC_IGN   = PC_W'(12);
    localparam logic [PC_W-1:0] PC_NOPD  = PC_W'(13);

    function automatic ctrl_t cw(rd_t rd, wr_t wr, hd_t hd, cnd_t cnd,
                                 logic [PC_W-1:0] tgt, logic dn, logic rm, logic ig);
        ctrl_t w;
        w.rd     = rd;
        w.wr     = wr;
        w.hd     = hd;
        w.cnd    = cnd;
        w.target = tgt;
        w.done   = dn;
        w.rem    = rm;
        w.ign    = ig;
        return w;
    endfunction

    function automatic ctrl_t rom(logic [PC_W-1:0] a);
        ctrl_t w;
        unique case (a)
            // insert front
            4'd0:    w = cw(RD_NONE, WR_NONE,   HD_KEEP,   C_NULL,      PC_IGN,   1'b0, 1'b0, 1'b0);
            4'd1:    w = cw(RD_HEAD, WR_NONE,   HD_KEEP,   C_EMPTY,     PC_INS_E, 1'b0, 1'b0, 1'b0);
            4'd2:    w = cw(RD_NONE, WR_NODE,   HD_KEEP,   C_NEXT,      PC_INS,   1'b0, 1'b0, 1'b0);
            4'd3:    w = cw(RD_NONE, WR_NBR,    HD_SET,    C_NEXT,      PC_INS,   1'b1, 1'b0, 1'b0);
            4'd4:    w = cw(RD_NONE, WR_SELF,   HD_SET,    C_NEXT,      PC_INS,   1'b1, 1'b0, 1'b0);
            // append tail
            4'd5:    w = cw(RD_HEAD, WR_NONE,   HD_KEEP,   C_SKIP,      PC_IGN,   1'b0, 1'b0, 1'b0);
            4'd6:    w = cw(RD_NONE, WR_NODE,   HD_KEEP,   C_NEXT,      PC_INS,   1'b0, 1'b0, 1'b0);
            4'd7:    w = cw(RD_NONE, WR_NBR,    HD_KEEP,   C_NEXT,      PC_INS,   1'b1, 1'b0, 1'b0);
            // remove given node and pop front
            4'd8:    w = cw(RD_NODE, WR_NONE,   HD_KEEP,   C_NO_VICTIM, PC_NOPD,  1'b0, 1'b0, 1'b0);
            4'd9:    w = cw(RD_NONE, WR_NONE,   HD_KEEP,   C_SELF,      PC_REM_S, 1'b0, 1'b0, 1'b0);
            4'd10:   w = cw(RD_NONE, WR_UNLINK, HD_UNLINK, C_NEXT,      PC_INS,   1'b1, 1'b1, 1'b0);
            4'd11:   w = cw(RD_NONE, WR_NONE,   HD_CLEAR,  C_NEXT,      PC_INS,   1'b1, 1'b1, 1'b0);
            4'd12:   w = cw(RD_NONE, WR_NONE,   HD_KEEP,   C_NEXT,      PC_INS,   1'b1, 1'b0, 1'b1);
            default: w = cw(RD_NONE, WR_NONE,   HD_KEEP,   C_NEXT,      PC_INS,   1'b1, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic            busy_reg;
    logic            take;
    logic [PC_W-1:0] entry;

    assign ctrl = rom(pc_reg);
    assign busy = busy_reg;
    // hold the finishing step while the result slot is still full and stalled
    assign fire = busy_reg && (!ctrl.done || out_free);

    always_comb
    begin
        unique case (ctrl.cnd)
            C_NULL:      take = stat.is_null;
            C_EMPTY:     take = stat.empty;
            C_SKIP:      take = stat.is_null || stat.empty;
            C_NO_VICTIM: take = stat.no_victim;
            C_SELF:      take = stat.self_loop;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (op)
            OP_INS:  entry = PC_INS;
            OP_APP:  entry = PC_APP;
            default: entry = PC_REM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_INS;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            pc_reg   <= entry;
            busy_reg <= 1'b1;
        end
        else if (fire)
        begin
            if (ctrl.done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                pc_reg <= take ? ctrl.target : pc_reg + PC_W'(1);
            end
        end
    end

endmodule

### sv/circular_dlist_manager_core.sv
// Top level of the circular doubly linked list manager: datapath, head table, output register.
// Depends on cdl_pkg, cdl_seq, cdl_ram and circular_dlist_manager_core_defines.svh.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  operation, list_id, node, node_is_null
//   out      source     out_valid/out_stall  removed_node, removed_valid, head_node,
//                                            list_empty, ignored
//
// An item runs as a sequence of microcode steps after the accept cycle; insert on a
// non-empty list is longest (read prev at head, then two writes to each link RAM).
// The single write port of each link RAM sets the step count.
// Reset clears the head table and occupied flags; link RAMs are not cleared.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and its final step holds only while that register is still full and stalled.
`include "circular_dlist_manager_core_defines.svh"

module circular_dlist_manager_core import cdl_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [LIST_W-1:0] list_id,
    input  logic [NODE_W-1:0] node,
    input  logic              node_is_null,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [NODE_W-1:0] removed_node,
    output logic              removed_valid,
    output logic [NODE_W-1:0] head_node,
    output logic              list_empty,
    output logic              ignored
);

    logic              accept;
    op_t               op_reg;
    logic [LIST_W-1:0] lst_reg;
    logic [NODE_W-1:0] node_reg;
    logic              null_reg;

    logic [NODE_W-1:0]     head_reg [LIST_COUNT];
    logic [LIST_COUNT-1:0] occ_reg;

    ctrl_t ctrl;
    stat_t stat;
    logic  fire;
    logic  busy;
    logic  out_free;
    logic  out_valid_reg;

    logic [NODE_W-1:0] cur_head;
    logic              cur_occ;
    logic [NODE_W-1:0] next_rd;
    logic [NODE_W-1:0] prev_rd;

    logic              nx_we;
    logic [NODE_W-1:0] nx_waddr;
    logic [NODE_W-1:0] nx_wdata;
    logic              pv_we;
    logic [NODE_W-1:0] pv_waddr;
    logic [NODE_W-1:0] pv_wdata;
    logic              nx_re;
    logic              pv_re;
    logic [NODE_W-1:0] pv_raddr;

    logic              hd_we;
    logic [NODE_W-1:0] head_next;
    logic              occ_next;

    assign accept   = in_valid && !busy;
    assign in_stall = busy;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    assign cur_head = head_reg[lst_reg];
    assign cur_occ  = occ_reg[lst_reg];

    assign stat.is_null   = null_reg;
    assign stat.empty     = !cur_occ;
    assign stat.self_loop = (next_rd == node_reg);
    assign stat.no_victim = (op_reg == OP_REM) ? null_reg : !cur_occ;

    cdl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .op       (op_t'(operation)),
        .stat     (stat),
        .out_free (out_free),
        .ctrl     (ctrl),
        .fire     (fire),
        .busy     (busy)
    );

    // capture the item; pop works on the current head
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(operation);
            lst_reg  <= list_id;
            node_reg <= (op_t'(operation) == OP_POP) ? head_reg[list_id] : node;
            null_reg <= node_is_null;
        end
    end

    // link RAM ports
    assign nx_re    = fire && (ctrl.rd == RD_NODE);
    assign pv_re    = fire && (ctrl.rd != RD_NONE);
    assign pv_raddr = (ctrl.rd == RD_HEAD) ? cur_head : node_reg;

    always_comb
    begin
        nx_we    = 1'b0;
        pv_we    = 1'b0;
        nx_waddr = node_reg;
        nx_wdata = node_reg;
        pv_waddr = node_reg;
        pv_wdata = node_reg;
        unique case (ctrl.wr)
            WR_SELF:
            begin
                nx_we = fire;
                pv_we = fire;
            end
            WR_NODE:
            begin
                nx_we    = fire;
                pv_we    = fire;
                nx_wdata = cur_head;
                pv_wdata = prev_rd;
            end
            WR_NBR:
            begin
                nx_we    = fire;
                pv_we    = fire;
                nx_waddr = prev_rd;
                pv_waddr = cur_head;
            end
            WR_UNLINK:
            begin
                nx_we    = fire;
                pv_we    = fire;
                nx_waddr = prev_rd;
                nx_wdata = next_rd;
                pv_waddr = next_rd;
                pv_wdata = prev_rd;
            end
            default:
            begin
                nx_we = 1'b0;
            end
        endcase
    end

    cdl_ram #(.DEPTH(NODE_COUNT), .DATA_W(NODE_W)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .re    (nx_re),
        .raddr (node_reg),
        .rdata (next_rd)
    );

    cdl_ram #(.DEPTH(NODE_COUNT), .DATA_W(NODE_W)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .re    (pv_re),
        .raddr (pv_raddr),
        .rdata (prev_rd)
    );

    // head and occupied flag of the selected list after this step
    always_comb
    begin
        head_next = cur_head;
        occ_next  = cur_occ;
        unique case (ctrl.hd)
            HD_SET:
            begin
                head_next = node_reg;
                occ_next  = 1'b1;
            end
            HD_UNLINK:
            begin
                if (cur_occ && (cur_head == node_reg))
                begin
                    head_next = next_rd;
                end
            end
            HD_CLEAR:
            begin
                head_next = '0;
                occ_next  = 1'b0;
            end
            default:
            begin
                head_next = cur_head;
            end
        endcase
    end

    assign hd_we = fire && (ctrl.hd != HD_KEEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                head_reg[i] <= '0;
            end
            occ_reg <= '0;
        end
        else if (hd_we)
        begin
            head_reg[lst_reg] <= head_next;
            occ_reg[lst_reg]  <= occ_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && ctrl.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ctrl.done)
        begin
            removed_node  <= ctrl.rem ? node_reg : '0;
            removed_valid <= ctrl.rem;
            head_node     <= occ_next ? head_next : '0;
            list_empty    <= !occ_next;
            ignored       <= ctrl.ign;
        end
    end

    `CDL_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
    `CDL_ASSERT_NOW(a_write_busy, nx_we || pv_we || hd_we, busy)
    `CDL_ASSERT_NOW(a_empty_head, out_valid && list_empty, head_node == '0)
    `CDL_ASSERT_NOW(a_rem_not_ign, out_valid && removed_valid, !ignored)

endmodule
